### rtl/rte_pkg.sv
// route table engine package: depth, widths, entry record, command codes
// and controller/datapath command and status structs; no dependencies
package rte_pkg;

   localparam int TableDepth = 16;
   localparam int IdxW = $clog2(TableDepth);
   localparam int CntW = $clog2(TableDepth + 1);
   localparam int EntryW = 6 * 64 + 49;
   localparam logic [63:0] LinkLocalHi = 64'hfe80_0000_0000_0000;

   typedef enum logic [2:0] {
      CMD_ADD_UP = 3'd0,
      CMD_ADD_DOWN = 3'd1,
      CMD_REMOVE = 3'd2,
      CMD_REMOVE_SUB = 3'd3,
      CMD_SEARCH_ANY = 3'd4,
      CMD_SEARCH_IF = 3'd5,
      CMD_RSVD6 = 3'd6,
      CMD_RSVD7 = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      ST_DONE = 2'd0,
      ST_FOUND = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL = 2'd3
   } status_type;

   typedef struct packed {
      logic        downward;
      logic [7:0]  life;
      logic [7:0]  sequence_n;
      logic [7:0]  instance_n;
      logic [15:0] metric;
      logic [7:0]  iface;
      logic [63:0] graph_lo;
      logic [63:0] graph_hi;
      logic [63:0] gw_lo;
      logic [63:0] gw_hi;
      logic [63:0] dest_lo;
      logic [63:0] dest_hi;
   } entry_type;

   // controller to datapath
   typedef struct packed {
      logic            load_req;     // capture request
      logic            rd_en;        // read entry at rd_addr
      logic [IdxW-1:0] rd_addr;
      logic            wr_en;
      logic [IdxW-1:0] wr_addr;
      logic            wr_new;       // write request as full entry
      logic            wr_update;    // write read entry with new attributes
      logic            wr_copy;      // write read entry as is
      logic            hold_found;   // latch read entry as search result
      logic            clear_found;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      cmd_type cmd;
      logic    add_hit;
      logic    drop_hit;
      logic    search_hit;
   } dp_stat_type;

endpackage

### rtl/rte_ram.sv
// generic single-port-write, one-read ram with registered read
// no dependencies
module rte_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end
   assign rd_data = rd_data_ff;
endmodule

### rtl/rte_datapath.sv
// route table datapath: request register, entry ram, match logic, result
// depends on rte_pkg and rte_ram
module rte_datapath (
   input  logic                clock,
   input  rte_pkg::dp_cmd_type dp_cmd,
   output rte_pkg::dp_stat_type dp_stat,
   input  logic [2:0]          req_command,
   input  logic [63:0]         req_dest_hi,
   input  logic [63:0]         req_dest_lo,
   input  logic [63:0]         req_gateway_hi,
   input  logic [63:0]         req_gateway_lo,
   input  logic [7:0]          req_interface_index,
   input  logic [15:0]         req_route_metric,
   input  logic [63:0]         req_graph_id_hi,
   input  logic [63:0]         req_graph_id_lo,
   input  logic [7:0]          req_instance_req,
   input  logic [7:0]          req_sequence_req,
   input  logic [7:0]          req_life,
   output rte_pkg::entry_type  found_entry
);
   rte_pkg::cmd_type   cmd_ff;
   rte_pkg::entry_type req_ff;
   rte_pkg::entry_type rd_entry;
   rte_pkg::entry_type wr_entry;
   rte_pkg::entry_type found_ff;
   logic [rte_pkg::EntryW-1:0] rd_bits;

   always_ff @(posedge clock) begin
      if (dp_cmd.load_req) begin
         cmd_ff <= rte_pkg::cmd_type'(req_command);
         req_ff <= '{downward: req_command[0], life: req_life,
                     sequence_n: req_sequence_req, instance_n: req_instance_req,
                     metric: req_route_metric, iface: req_interface_index,
                     graph_lo: req_graph_id_lo, graph_hi: req_graph_id_hi,
                     gw_lo: req_gateway_lo, gw_hi: req_gateway_hi,
                     dest_lo: req_dest_lo, dest_hi: req_dest_hi};
      end
      if (dp_cmd.clear_found) begin
         found_ff <= '0;
      end else if (dp_cmd.hold_found) begin
         found_ff <= rd_entry;
      end
   end

   rte_ram #(.Width(rte_pkg::EntryW), .Depth(rte_pkg::TableDepth)) u_ram (
      .clock   (clock),
      .wr_en   (dp_cmd.wr_en),
      .wr_addr (dp_cmd.wr_addr),
      .wr_data (wr_entry),
      .rd_en   (dp_cmd.rd_en),
      .rd_addr (dp_cmd.rd_addr),
      .rd_data (rd_bits)
   );
   assign rd_entry = rte_pkg::entry_type'(rd_bits);

   always_comb begin
      wr_entry = rd_entry;
      if (dp_cmd.wr_new) begin
         wr_entry = req_ff;
      end else if (dp_cmd.wr_update) begin
         wr_entry = req_ff;
         wr_entry.dest_hi = rd_entry.dest_hi;
         wr_entry.dest_lo = rd_entry.dest_lo;
         wr_entry.gw_hi = rd_entry.gw_hi;
         wr_entry.gw_lo = rd_entry.gw_lo;
      end
   end

   logic dest_eq, gw_eq, if_eq, dest_zero, gw_zero;
   assign dest_eq = (rd_entry.dest_hi == req_ff.dest_hi) && (rd_entry.dest_lo == req_ff.dest_lo);
   assign gw_eq = (rd_entry.gw_hi == req_ff.gw_hi) && (rd_entry.gw_lo == req_ff.gw_lo);
   assign if_eq = rd_entry.iface == req_ff.iface;
   assign dest_zero = (req_ff.dest_hi == '0) && (req_ff.dest_lo == '0);
   assign gw_zero = (req_ff.gw_hi == '0) && (req_ff.gw_lo == '0);

   always_comb begin
      dp_stat.cmd = cmd_ff;
      dp_stat.add_hit = dest_eq && gw_eq && if_eq;
      dp_stat.search_hit = dest_eq && ((cmd_ff == rte_pkg::CMD_SEARCH_ANY) || if_eq);
      if (cmd_ff == rte_pkg::CMD_REMOVE) begin
         dp_stat.drop_hit = if_eq && ((!dest_zero && dest_eq) || (!gw_zero && gw_eq));
      end else begin
         dp_stat.drop_hit = (rd_entry.dest_hi != rte_pkg::LinkLocalHi)
            && (rd_entry.gw_hi == rte_pkg::LinkLocalHi) && rd_entry.downward
            && (rd_entry.graph_hi == req_ff.graph_hi)
            && (rd_entry.graph_lo == req_ff.graph_lo)
            && (rd_entry.instance_n == req_ff.instance_n);
      end
   end

   assign found_entry = found_ff;
endmodule

### rtl/rte_ctrl.sv
// route table controller: walks entries, handles count and handshakes
// depends on rte_pkg
module rte_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rte_pkg::status_type  status,
   output logic                 table_empty,
   output rte_pkg::dp_cmd_type  dp_cmd,
   input  rte_pkg::dp_stat_type dp_stat
);
   typedef enum logic [2:0] {S_IDLE, S_DECODE, S_READ, S_CHECK, S_RESP} state_type;

   state_type                 state_ff, state_in;
   logic [rte_pkg::CntW-1:0]  count_ff, count_in;
   logic [rte_pkg::CntW-1:0]  rd_ff, rd_in;
   logic [rte_pkg::CntW-1:0]  wr_ff, wr_in;
   rte_pkg::status_type       status_ff, status_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   logic is_add, is_rem, is_search;
   assign is_add = (dp_stat.cmd == rte_pkg::CMD_ADD_UP) || (dp_stat.cmd == rte_pkg::CMD_ADD_DOWN);
   assign is_rem = (dp_stat.cmd == rte_pkg::CMD_REMOVE) || (dp_stat.cmd == rte_pkg::CMD_REMOVE_SUB);
   assign is_search = (dp_stat.cmd == rte_pkg::CMD_SEARCH_ANY)
      || (dp_stat.cmd == rte_pkg::CMD_SEARCH_IF);

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      rd_in = rd_ff;
      wr_in = wr_ff;
      status_in = status_ff;
      rsp_valid_in = rsp_valid_ff;
      dp_cmd = '0;
      dp_cmd.rd_addr = rd_ff[rte_pkg::IdxW-1:0];
      dp_cmd.wr_addr = wr_ff[rte_pkg::IdxW-1:0];
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               dp_cmd.load_req = 1'b1;
               dp_cmd.clear_found = 1'b1;
               rd_in = '0;
               wr_in = '0;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            status_in = is_search ? rte_pkg::ST_NOT_FOUND : rte_pkg::ST_DONE;
            state_in = (is_add || is_rem || is_search) ? S_READ : S_RESP;
         end
         S_READ: begin
            if (rd_ff == count_ff) begin
               if (is_add) begin
                  if (count_ff == rte_pkg::CntW'(rte_pkg::TableDepth)) begin
                     status_in = rte_pkg::ST_FULL;
                  end else begin
                     dp_cmd.wr_en = 1'b1;
                     dp_cmd.wr_new = 1'b1;
                     dp_cmd.wr_addr = count_ff[rte_pkg::IdxW-1:0];
                     count_in = count_ff + 1'b1;
                  end
               end else if (is_rem) begin
                  count_in = wr_ff;
               end
               state_in = S_RESP;
            end else begin
               dp_cmd.rd_en = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            rd_in = rd_ff + 1'b1;
            state_in = S_READ;
            if (is_add && dp_stat.add_hit) begin
               dp_cmd.wr_en = 1'b1;
               dp_cmd.wr_update = 1'b1;
               dp_cmd.wr_addr = rd_ff[rte_pkg::IdxW-1:0];
               state_in = S_RESP;
            end else if (is_search && dp_stat.search_hit) begin
               dp_cmd.hold_found = 1'b1;
               status_in = rte_pkg::ST_FOUND;
               state_in = S_RESP;
            end else if (is_rem && !dp_stat.drop_hit) begin
               dp_cmd.wr_en = (wr_ff != rd_ff);
               dp_cmd.wr_copy = 1'b1;
               wr_in = wr_ff + 1'b1;
            end
         end
         S_RESP: begin
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
         status_ff <= rte_pkg::ST_DONE;
         rd_ff <= '0;
         wr_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         status_ff <= status_in;
         rd_ff <= rd_in;
         wr_ff <= wr_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign status = status_ff;
   assign table_empty = (count_ff == '0);
endmodule

### rtl/route_table_engine_core.sv
// route table engine top level: controller, datapath and result ports
// depends on rte_pkg, rte_ctrl, rte_datapath
//
// ordered route table of up to 16 routes kept in insertion order in one
// entry ram (one read, one write per cycle). every add, remove and search
// command walks the valid entries in turn, reading each and then checking
// it; reserved codes go straight to the response. adds and searches stop at
// the first hit. removals compact in place: survivors are copied down as the
// walk passes them. one transfer is taken at a time; the next request is
// accepted once the response has been taken. found_* fields are zero unless
// status reports found. there is no clearing pass after reset.
module route_table_engine_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_command,
   input  logic [63:0] req_dest_hi,
   input  logic [63:0] req_dest_lo,
   input  logic [63:0] req_gateway_hi,
   input  logic [63:0] req_gateway_lo,
   input  logic [7:0]  req_interface_index,
   input  logic [15:0] req_route_metric,
   input  logic [63:0] req_graph_id_hi,
   input  logic [63:0] req_graph_id_lo,
   input  logic [7:0]  req_instance_req,
   input  logic [7:0]  req_sequence_req,
   input  logic [7:0]  req_life,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic        rsp_table_empty,
   output logic [63:0] rsp_found_gateway_hi,
   output logic [63:0] rsp_found_gateway_lo,
   output logic [7:0]  rsp_found_interface,
   output logic [15:0] rsp_found_metric,
   output logic [63:0] rsp_found_graph_hi,
   output logic [63:0] rsp_found_graph_lo,
   output logic [7:0]  rsp_found_instance,
   output logic [7:0]  rsp_found_sequence,
   output logic [7:0]  rsp_found_life,
   output logic        rsp_found_downward
);
   rte_pkg::dp_cmd_type  dp_cmd;
   rte_pkg::dp_stat_type dp_stat;
   rte_pkg::entry_type   found;
   rte_pkg::status_type  status;

   // sequencer: walk, compaction and count
   rte_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .status      (status),
      .table_empty (rsp_table_empty),
      .dp_cmd      (dp_cmd),
      .dp_stat     (dp_stat)
   );

   // entry storage and compares
   rte_datapath u_dp (
      .clock               (clock),
      .dp_cmd              (dp_cmd),
      .dp_stat             (dp_stat),
      .req_command         (req_command),
      .req_dest_hi         (req_dest_hi),
      .req_dest_lo         (req_dest_lo),
      .req_gateway_hi      (req_gateway_hi),
      .req_gateway_lo      (req_gateway_lo),
      .req_interface_index (req_interface_index),
      .req_route_metric    (req_route_metric),
      .req_graph_id_hi     (req_graph_id_hi),
      .req_graph_id_lo     (req_graph_id_lo),
      .req_instance_req    (req_instance_req),
      .req_sequence_req    (req_sequence_req),
      .req_life            (req_life),
      .found_entry         (found)
   );

   // result fields: found_* zeroed at accept; all held until the response transfer
   assign rsp_status = status;
   assign rsp_found_gateway_hi = found.gw_hi;
   assign rsp_found_gateway_lo = found.gw_lo;
   assign rsp_found_interface = found.iface;
   assign rsp_found_metric = found.metric;
   assign rsp_found_graph_hi = found.graph_hi;
   assign rsp_found_graph_lo = found.graph_lo;
   assign rsp_found_instance = found.instance_n;
   assign rsp_found_sequence = found.sequence_n;
   assign rsp_found_life = found.life;
   assign rsp_found_downward = found.downward;
endmodule
